FILE: rtl/core/peak_charge_gate_accumulator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the peak charge gate accumulator
// Two property forms, sampled on the rising clock edge and muted during reset.
// ----------------------------------------------------------------------------
`ifndef PEAK_CHARGE_GATE_ACCUMULATOR_ASSERT_SVH
`define PEAK_CHARGE_GATE_ACCUMULATOR_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/core/pcga_pkg.sv
// ----------------------------------------------------------------------------
// pcga_pkg
// Shared widths, request codes and types of the peak charge gate accumulator.
// ----------------------------------------------------------------------------
package pcga_pkg;

  localparam int ADC_W   = 10;  // raw sample
  localparam int CHAN_W  = 7;   // channel / entry field
  localparam int MEAN_W  = 14;  // Q10.4 pedestal mean and mean charge
  localparam int SIGMA_W = 12;  // Q8.4 pedestal sigma
  localparam int CUT_W   = 8;   // Q4.4 sigma cut
  localparam int SUM_W   = 32;  // charge sum
  localparam int HIT_W   = 16;  // reported hit count
  localparam int PED_W   = MEAN_W + SIGMA_W;

  localparam int DEF_CHANNELS   = 64;
  localparam int DEF_COUNT_BITS = 16;

  localparam logic [CUT_W-1:0]  SIGMA_CUT_RESET = CUT_W'(48);
  localparam logic [MEAN_W-1:0] MEAN_MAX        = '1;

  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_LOAD   = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  // end of a clock train, as seen by the accumulate path
  typedef struct packed {
    logic             fire;
    logic [ADC_W-1:0] peak;
    logic             flag;
  } train_end_t;

endpackage

FILE: rtl/core/pcga_ram.sv
// ----------------------------------------------------------------------------
// pcga_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pcga_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/pcga_peak.sv
// ----------------------------------------------------------------------------
// pcga_peak
// Running peak tracker over one clock train; flags the train end.
// ----------------------------------------------------------------------------
module pcga_peak
  import pcga_pkg::*;
#(
  parameter int CHANNELS = DEF_CHANNELS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_en,   // sample transfer this edge
  input  logic [CHAN_W-1:0] channel,
  input  logic [ADC_W-1:0]  adc_sample,
  input  logic              integrator_flag,
  input  logic              train_end,
  output train_end_t        ev
);

  logic             open;
  logic [ADC_W-1:0] peak_value;
  logic             peak_flag;

  logic             chan_ok;
  logic             base_flag;
  logic [ADC_W-1:0] peak_next;
  logic             flag_next;

  always_comb begin
    chan_ok   = (channel < CHANNELS);
    // first sample of a train seeds the flag (flat train case)
    base_flag = open ? peak_flag : integrator_flag;
    if (adc_sample > peak_value) begin
      peak_next = adc_sample;
      flag_next = integrator_flag;
    end else begin
      peak_next = peak_value;
      flag_next = base_flag;
    end
    ev.fire = sample_en && chan_ok && train_end;
    ev.peak = peak_next;
    ev.flag = flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open       <= 1'b0;
      peak_value <= '0;
      peak_flag  <= 1'b0;
    end else if (sample_en && chan_ok) begin
      if (train_end) begin
        open       <= 1'b0;
        peak_value <= '0;
        peak_flag  <= 1'b0;
      end else begin
        open       <= 1'b1;
        peak_value <= peak_next;
        peak_flag  <= flag_next;
      end
    end
  end

endmodule

FILE: rtl/core/pcga_gate.sv
// ----------------------------------------------------------------------------
// pcga_gate
// Pedestal subtraction, sigma gate and saturating accumulate of one entry.
// ----------------------------------------------------------------------------
module pcga_gate
  import pcga_pkg::*;
#(
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic [ADC_W-1:0]            peak,
  input  logic [CUT_W-1:0]            sigma_cut,
  input  logic [PED_W-1:0]            ped_word,   // {mean, sigma}
  input  logic [SUM_W+COUNT_BITS-1:0] acc_word,   // {count, sum}
  output logic                        hit,
  output logic [SUM_W+COUNT_BITS-1:0] acc_new
);

  localparam int DIFF_W = MEAN_W + 2;
  localparam int THR_W  = CUT_W + SIGMA_W;

  logic [MEAN_W-1:0]     ped_mean;
  logic [SIGMA_W-1:0]    ped_sigma;
  logic [SUM_W-1:0]      sum;
  logic [COUNT_BITS-1:0] count;
  logic [DIFF_W-1:0]     diff;
  logic [MEAN_W-1:0]     charge;
  logic [THR_W-1:0]      thr;
  logic [THR_W-1:0]      charge_q8;
  logic [SUM_W:0]        sum_wide;
  logic [SUM_W-1:0]      sum_next;
  logic [COUNT_BITS-1:0] count_next;

  always_comb begin
    ped_mean  = ped_word[PED_W-1:SIGMA_W];
    ped_sigma = ped_word[SIGMA_W-1:0];
    sum       = acc_word[SUM_W-1:0];
    count     = acc_word[SUM_W+COUNT_BITS-1:SUM_W];

    // Q.4 charge; sign bit is the top of diff
    diff      = {2'b00, peak, 4'b0000} - {2'b00, ped_mean};
    charge    = diff[MEAN_W-1:0];
    thr       = THR_W'(sigma_cut) * THR_W'(ped_sigma);
    charge_q8 = THR_W'({charge, 4'b0000});
    hit       = !diff[DIFF_W-1] && (diff != '0) && (charge_q8 > thr);

    sum_wide  = {1'b0, sum} + (SUM_W + 1)'(charge);
    sum_next  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    count_next = (count == '1) ? count : count + 1'b1;
    acc_new   = {count_next, sum_next};
  end

endmodule

FILE: rtl/core/pcga_div.sv
// ----------------------------------------------------------------------------
// pcga_div
// Restoring divider, one quotient bit per cycle, result clipped to Q10.4.
// ----------------------------------------------------------------------------
module pcga_div
  import pcga_pkg::*;
#(
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  logic [SUM_W-1:0]      dividend,
  input  logic [COUNT_BITS-1:0] divisor,
  output logic                  done,
  output logic [MEAN_W-1:0]     quotient
);

  localparam int STEP_W = $clog2(SUM_W);

  logic                  active;
  logic [STEP_W-1:0]     step;
  logic [COUNT_BITS-1:0] den;
  logic [COUNT_BITS-1:0] rem;
  logic [SUM_W-1:0]      quo;

  logic [COUNT_BITS:0]   trial;
  logic                  qbit;
  logic [COUNT_BITS-1:0] rem_next;
  logic [SUM_W-1:0]      quo_next;

  always_comb begin
    trial    = {rem, quo[SUM_W-1]};
    qbit     = (trial >= {1'b0, den});
    rem_next = qbit ? COUNT_BITS'(trial - {1'b0, den}) : trial[COUNT_BITS-1:0];
    quo_next = {quo[SUM_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      step   <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        active <= 1'b1;
        step   <= '0;
        den    <= divisor;
        rem    <= '0;
        quo    <= dividend;
      end else if (active) begin
        rem  <= rem_next;
        quo  <= quo_next;
        step <= step + 1'b1;
        if (step == STEP_W'(SUM_W - 1)) begin
          active   <= 1'b0;
          done     <= 1'b1;
          quotient <= (quo_next[SUM_W-1:MEAN_W] != '0) ? MEAN_MAX
                                                      : quo_next[MEAN_W-1:0];
        end
      end
    end
  end

endmodule

FILE: rtl/core/peak_charge_gate_accumulator.sv
// ----------------------------------------------------------------------------
// peak_charge_gate_accumulator
// Sample, load and sigma_cut transfers need no follow-up state; a train-end
// sample does the pedestal and accumulator read, then the gated write-back. A
// read waits on the bit-serial mean divider for its strobe; it skips the
// divider when the hit count is zero. After rst the accumulator RAM is
// cleared, one entry a cycle, over all 2*CHANNELS entries with busy high;
// sigma_cut resets to 3.0. Results cannot be stalled.
// ----------------------------------------------------------------------------
`include "peak_charge_gate_accumulator_assert.svh"

module peak_charge_gate_accumulator
  import pcga_pkg::*;
#(
  parameter int CHANNELS   = DEF_CHANNELS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic               clk,
  input  logic               rst,
  // command side
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type,
  input  logic [CHAN_W-1:0]  channel,
  input  logic [ADC_W-1:0]   adc_sample,
  input  logic               integrator_flag,
  input  logic               train_end,
  input  logic [MEAN_W-1:0]  ped_mean,
  input  logic [SIGMA_W-1:0] ped_sigma,
  // sigma_cut register
  input  logic               cfg_we,
  input  logic [CUT_W-1:0]   cfg_data,
  // result side
  output logic               done,
  output logic [CHAN_W-1:0]  entry,
  output logic [SUM_W-1:0]   charge_sum,
  output logic [HIT_W-1:0]   hit_count,
  output logic [MEAN_W-1:0]  mean_charge
);

  // Table holds one entry per channel and integrator.
  localparam int DEPTH  = 2 * CHANNELS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ACC_W  = SUM_W + COUNT_BITS;

  typedef enum logic [2:0] {
    ST_CLEAR,   // post-reset sweep of the accumulator RAM
    ST_IDLE,
    ST_TRAIN,   // RAM data back, gate and write back
    ST_FETCH,   // RAM data back for a read
    ST_DIV      // waiting on the mean
  } state_t;

  state_t             state;
  logic [ADDR_W-1:0]  clr_addr;
  logic [ADDR_W-1:0]  pend_addr;    // entry under work
  logic [ADC_W-1:0]   pend_peak;
  logic [CHAN_W-1:0]  pend_entry;
  logic               pend_in_range;
  logic [CUT_W-1:0]   sigma_cut;

  logic               accept;
  req_t               req;
  train_end_t         ev;
  logic [ADDR_W-1:0]  ev_addr;
  logic               chan_in_table;

  logic               ped_we;
  logic [PED_W-1:0]   ped_rdata;
  logic               acc_we;
  logic [ADDR_W-1:0]  acc_waddr;
  logic [ACC_W-1:0]   acc_wdata;
  logic [ADDR_W-1:0]  acc_raddr;
  logic [ACC_W-1:0]   acc_rdata;

  logic               hit;
  logic [ACC_W-1:0]   acc_new;

  logic [SUM_W-1:0]      rd_sum;
  logic [COUNT_BITS-1:0] rd_count;
  logic                  div_go;
  logic                  div_done;
  logic [MEAN_W-1:0]     div_quo;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign req    = req_t'(req_type);

  assign chan_in_table = (channel < DEPTH);

  // Train end picks channel + CHANNELS*flag; channel is already below CHANNELS.
  assign ev_addr = ADDR_W'(channel) + (ev.flag ? ADDR_W'(CHANNELS) : '0);

  pcga_peak #(
    .CHANNELS(CHANNELS)
  ) u_peak (
    .clk             (clk),
    .rst             (rst),
    .sample_en       (accept && (req == REQ_SAMPLE)),
    .channel         (channel),
    .adc_sample      (adc_sample),
    .integrator_flag (integrator_flag),
    .train_end       (train_end),
    .ev              (ev)
  );

  // Pedestal RAM: written straight from a load transfer, read on train end.
  assign ped_we = accept && (req == REQ_LOAD) && chan_in_table;

  pcga_ram #(
    .WIDTH(PED_W),
    .DEPTH(DEPTH)
  ) u_ped_ram (
    .clk   (clk),
    .we    (ped_we),
    .waddr (ADDR_W'(channel)),
    .wdata ({ped_mean, ped_sigma}),
    .raddr (ev_addr),
    .rdata (ped_rdata)
  );

  // Accumulator RAM: {count, sum}. The read address comes from the transfer
  // itself; write-back happens in the next cycle while busy blocks new work,
  // so read and write of the same entry never overlap.
  always_comb begin
    acc_raddr = (req == REQ_READ) ? ADDR_W'(channel) : ev_addr;
    if (state == ST_CLEAR) begin
      acc_we    = 1'b1;
      acc_waddr = clr_addr;
      acc_wdata = '0;
    end else begin
      acc_we    = (state == ST_TRAIN) && hit;
      acc_waddr = pend_addr;
      acc_wdata = acc_new;
    end
  end

  pcga_ram #(
    .WIDTH(ACC_W),
    .DEPTH(DEPTH)
  ) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  pcga_gate #(
    .COUNT_BITS(COUNT_BITS)
  ) u_gate (
    .peak      (pend_peak),
    .sigma_cut (sigma_cut),
    .ped_word  (ped_rdata),
    .acc_word  (acc_rdata),
    .hit       (hit),
    .acc_new   (acc_new)
  );

  // Entries past the table read back as all zero.
  assign rd_sum   = pend_in_range ? acc_rdata[SUM_W-1:0] : '0;
  assign rd_count = pend_in_range ? acc_rdata[ACC_W-1:SUM_W] : '0;
  assign div_go   = (state == ST_FETCH) && (rd_count != '0);

  pcga_div #(
    .COUNT_BITS(COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (rd_sum),
    .divisor  (rd_count),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sigma_cut <= SIGMA_CUT_RESET;
    end else if (cfg_we) begin
      sigma_cut <= cfg_data;
    end
  end

  // Sequencer: state, work registers and the result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && ev.fire) begin
            pend_addr <= ev_addr;
            pend_peak <= ev.peak;
            state     <= ST_TRAIN;
          end else if (accept && (req == REQ_READ)) begin
            pend_entry    <= channel;
            pend_in_range <= chan_in_table;
            state         <= ST_FETCH;
          end
        end
        ST_TRAIN: begin
          state <= ST_IDLE;
        end
        ST_FETCH: begin
          entry      <= pend_entry;
          charge_sum <= rd_sum;
          hit_count  <= HIT_W'(rd_count);
          if (rd_count == '0) begin
            mean_charge <= '0;
            done        <= 1'b1;
            state       <= ST_IDLE;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            mean_charge <= div_quo;
            done        <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A result transfer always leaves the block ready for the next command.
  `ASSERT_IMPLIES(a_done_idle, clk, rst, done, !busy)
  // Train write-back always returns to idle in the next cycle.
  `ASSERT_NEXT(a_train_once, clk, rst, state == ST_TRAIN, state == ST_IDLE)
  // The divider only finishes while the sequencer waits on it.
  `ASSERT_IMPLIES(a_div_owner, clk, rst, div_done, state == ST_DIV)
  // Empty sum reports a zero mean.
  `ASSERT_IMPLIES(a_zero_mean, clk, rst, done && (charge_sum == '0), mean_charge == '0)

endmodule

FILE: tb/peak_charge_gate_accumulator_tb.sv
// ----------------------------------------------------------------------------
// peak_charge_gate_accumulator_tb
// Self-checking bench for the peak charge gate accumulator. Sample, pedestal
// load, readback and unused commands go in through start/busy. A scoreboard
// tracks the train peak, the sigma gate and the saturating accumulators, and
// checks every readback transfer field by field.
// ----------------------------------------------------------------------------
module peak_charge_gate_accumulator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pcga_pkg::*;

  localparam int CHANNELS = DEF_CHANNELS;
  localparam int ENTRIES  = 2 * CHANNELS;
  localparam int CHAN_MAX = (1 << CHAN_W) - 1;
  localparam longint unsigned SUM_MAX   = 64'hFFFF_FFFF;
  localparam longint unsigned COUNT_MAX = (64'd1 << DEF_COUNT_BITS) - 1;
  localparam longint unsigned MEAN_TOP  = (64'd1 << MEAN_W) - 1;
  // settle margin in clock cycles, chosen above the readback delay
  localparam int LATENCY     = 40;
  localparam int CYCLE_LIMIT = 2_000_000;

  // one command as it appears on the input ports
  typedef struct packed {
    req_t                 req;
    logic [CHAN_W-1:0]    chan;
    logic [ADC_W-1:0]     adc;
    logic                 flag;
    logic                 last;
    logic [MEAN_W-1:0]    mean;
    logic [SIGMA_W-1:0]   sigma;
  } cmd_t;

  // one readback transfer
  typedef struct packed {
    logic [CHAN_W-1:0]    entry;
    logic [SUM_W-1:0]     sum;
    logic [HIT_W-1:0]     hits;
    logic [MEAN_W-1:0]    mean;
  } readback_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors peak tracking, sigma gate and accumulators, and holds
  // the readbacks still owed by the block.
  // --------------------------------------------------------------------------
  class gate_scoreboard;
    logic [CUT_W-1:0]   cut;
    logic [ADC_W-1:0]   peak;
    logic               peak_flag;
    bit                 train_open;
    logic [MEAN_W-1:0]  ped_mean [ENTRIES];
    logic [SIGMA_W-1:0] ped_sigma [ENTRIES];
    longint unsigned    sum_acc [ENTRIES];
    longint unsigned    count_acc [ENTRIES];
    readback_t          owed [$];
    int                 errors;
    int                 commands;
    int                 readbacks_checked;
    int                 accepted_trains;
    int                 gated_trains;

    function new();
      cut = SIGMA_CUT_RESET;
      peak = '0;
      peak_flag = 1'b0;
      train_open = 1'b0;
      foreach (sum_acc[i]) begin
        sum_acc[i] = 0;
        count_acc[i] = 0;
        ped_mean[i] = '0;
        ped_sigma[i] = '0;
      end
      errors = 0;
      commands = 0;
      readbacks_checked = 0;
      accepted_trains = 0;
      gated_trains = 0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // called once per accepted start transfer, in order
    function void note(cmd_t c);
      int unsigned     idx;
      longint          pk, pm, ps, ct, charge, thr;
      longint unsigned s, n, m;
      readback_t       rb;
      commands++;
      case (c.req)
        REQ_SAMPLE: begin
          if (c.chan < CHANNELS) begin
            // flag of the first sample stands until some sample beats the peak
            if (!train_open) begin
              peak_flag = c.flag;
              train_open = 1'b1;
            end
            if (c.adc > peak) begin
              peak = c.adc;
              peak_flag = c.flag;
            end
            if (c.last) begin
              idx = c.chan + CHANNELS * peak_flag;
              pk = peak;
              pm = ped_mean[idx];
              ps = ped_sigma[idx];
              ct = cut;
              charge = pk * 16 - pm;     // Q.4
              thr = ct * ps;             // Q.8
              if (charge * 16 > thr) begin
                s = sum_acc[idx] + charge;
                sum_acc[idx] = (s > SUM_MAX) ? SUM_MAX : s;
                if (count_acc[idx] < COUNT_MAX) count_acc[idx]++;
                accepted_trains++;
              end else begin
                gated_trains++;
              end
              peak = '0;
              peak_flag = 1'b0;
              train_open = 1'b0;
            end
          end
        end
        REQ_LOAD: begin
          ped_mean[c.chan] = c.mean;
          ped_sigma[c.chan] = c.sigma;
        end
        REQ_READ: begin
          s = sum_acc[c.chan];
          n = count_acc[c.chan];
          m = 0;
          if (n != 0) begin
            m = s / n;
            if (m > MEAN_TOP) m = MEAN_TOP;
          end
          rb.entry = c.chan;
          rb.sum = s[SUM_W-1:0];
          rb.hits = n[HIT_W-1:0];
          rb.mean = m[MEAN_W-1:0];
          owed.push_back(rb);
        end
        default: ;
      endcase
    endfunction

    function void check(readback_t got);
      readback_t want;
      if (owed.size() == 0) begin
        $error("readback of entry %0d with nothing owed", got.entry);
        errors++;
        return;
      end
      want = owed.pop_front();
      readbacks_checked++;
      if (got.entry !== want.entry) begin
        $error("entry: expected %0d, got %0d", want.entry, got.entry);
        errors++;
      end
      if (got.sum !== want.sum) begin
        $error("charge_sum: expected %0d, got %0d", want.sum, got.sum);
        errors++;
      end
      if (got.hits !== want.hits) begin
        $error("hit_count: expected %0d, got %0d", want.hits, got.hits);
        errors++;
      end
      if (got.mean !== want.mean) begin
        $error("mean_charge: expected %0d, got %0d", want.mean, got.mean);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         req_type;
  logic [CHAN_W-1:0]  channel;
  logic [ADC_W-1:0]   adc_sample;
  logic               integrator_flag;
  logic               train_end;
  logic [MEAN_W-1:0]  ped_mean;
  logic [SIGMA_W-1:0] ped_sigma;
  logic               cfg_we;
  logic [CUT_W-1:0]   cfg_data;
  logic               done;
  logic [CHAN_W-1:0]  entry;
  logic [SUM_W-1:0]   charge_sum;
  logic [HIT_W-1:0]   hit_count;
  logic [MEAN_W-1:0]  mean_charge;

  gate_scoreboard sb = new();
  bit             idling;       // random gaps on the command side
  int             cut_writes;
  int unsigned    cycles;

  peak_charge_gate_accumulator u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .channel(channel),
    .adc_sample(adc_sample),
    .integrator_flag(integrator_flag),
    .train_end(train_end),
    .ped_mean(ped_mean),
    .ped_sigma(ped_sigma),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .done(done),
    .entry(entry),
    .charge_sum(charge_sum),
    .hit_count(hit_count),
    .mean_charge(mean_charge)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // results cannot be held off: every strobe is a transfer
  always @(posedge clk) begin
    if (!rst && done === 1'b1)
      sb.check(readback_t'{entry, charge_sum, hit_count, mean_charge});
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("peak_charge_gate_accumulator_tb NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Command builders: fields a command ignores still carry random bits
  // --------------------------------------------------------------------------
  function automatic cmd_t scramble();
    cmd_t c;
    c.req   = req_t'($urandom_range(0, 3));
    c.chan  = CHAN_W'($urandom);
    c.adc   = ADC_W'($urandom);
    c.flag  = 1'($urandom);
    c.last  = 1'($urandom);
    c.mean  = MEAN_W'($urandom);
    c.sigma = SIGMA_W'($urandom);
    return c;
  endfunction

  function automatic cmd_t sample_cmd(int ch, int adc, bit flag, bit last);
    cmd_t c;
    c = scramble();
    c.req  = REQ_SAMPLE;
    c.chan = CHAN_W'(ch);
    c.adc  = ADC_W'(adc);
    c.flag = flag;
    c.last = last;
    return c;
  endfunction

  function automatic cmd_t load_cmd(int e, int m, int s);
    cmd_t c;
    c = scramble();
    c.req   = REQ_LOAD;
    c.chan  = CHAN_W'(e);
    c.mean  = MEAN_W'(m);
    c.sigma = SIGMA_W'(s);
    return c;
  endfunction

  function automatic cmd_t read_cmd(int e);
    cmd_t c;
    c = scramble();
    c.req  = REQ_READ;
    c.chan = CHAN_W'(e);
    return c;
  endfunction

  // random pedestal; sigma mostly small so the gate opens often enough
  function automatic cmd_t ped_load(int e);
    return load_cmd(e, $urandom_range(0, (1 << MEAN_W) - 1),
                    ($urandom_range(0, 7) == 0) ? $urandom_range(0, (1 << SIGMA_W) - 1)
                                                : $urandom_range(0, 255));
  endfunction

  // commands the block drops: unused code or a sample on a missing channel
  function automatic cmd_t noise_cmd();
    cmd_t c;
    c = scramble();
    if ($urandom_range(0, 1) == 0) begin
      c.req = REQ_NONE;
    end else begin
      c.req  = REQ_SAMPLE;
      c.chan = CHAN_W'($urandom_range(CHANNELS, CHAN_MAX));
    end
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Driving tasks
  // --------------------------------------------------------------------------
  // Start stays high across back-to-back commands; only a gap lowers it.
  task automatic send(cmd_t c);
    start           <= 1'b1;
    req_type        <= c.req;
    channel         <= c.chan;
    adc_sample      <= c.adc;
    integrator_flag <= c.flag;
    train_end       <= c.last;
    ped_mean        <= c.mean;
    ped_sigma       <= c.sigma;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note(c);
    if (idling && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // let every owed readback arrive, then let a train-end write-back finish
  task automatic settle();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_cut(int v);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= CUT_W'(v);
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.cut = CUT_W'(v);
    cut_writes++;
  endtask

  // well-formed train on one channel, sometimes broken by a wandering
  // channel or by stray commands slipped in between samples
  task automatic random_train(output int sent);
    int len, ch, adc;
    bit wander, flat;
    len = $urandom_range(1, 6);
    ch = $urandom_range(0, CHANNELS - 1);
    wander = ($urandom_range(0, 9) == 0);
    flat = ($urandom_range(0, 11) == 0);
    sent = 0;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) send(noise_cmd());
      if ($urandom_range(0, 15) == 0) begin
        send(read_cmd($urandom_range(0, ENTRIES - 1)));
        sent++;
      end
      if (flat) adc = 0;
      else if ($urandom_range(0, 7) == 0) adc = (1 << ADC_W) - 1;
      else adc = $urandom_range(0, (1 << ADC_W) - 1);
      send(sample_cmd(wander ? $urandom_range(0, CHANNELS - 1) : ch, adc,
                      1'($urandom_range(0, 1)), i == len - 1));
      sent++;
    end
  endtask

  task automatic random_phase(int n);
    int sent, k;
    sent = 0;
    while (sent < n) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          send(read_cmd($urandom_range(0, ENTRIES - 1)));
          sent++;
          // sender holds off until the block has nothing owed
          if ($urandom_range(0, 5) == 0) settle();
        end
        2: begin
          send(ped_load($urandom_range(0, ENTRIES - 1)));
          sent++;
        end
        3: send(noise_cmd());
        default: begin
          random_train(k);
          sent += k;
        end
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    rst             <= 1'b1;
    start           <= 1'b0;
    req_type        <= REQ_NONE;
    channel         <= '0;
    adc_sample      <= '0;
    integrator_flag <= 1'b0;
    train_end       <= 1'b0;
    ped_mean        <= '0;
    ped_sigma       <= '0;
    cfg_we          <= 1'b0;
    cfg_data        <= '0;
    cycles          <= 0;
    idling = 1'b0;
    cut_writes = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // accumulator clear pass holds busy high
    @(posedge clk);
    while (busy) @(posedge clk);

    // accumulators must read zero straight out of reset
    send(read_cmd(0));
    send(read_cmd(ENTRIES - 1));

    // every pedestal is written before any train can land on it
    for (int e = 0; e < ENTRIES; e++) send(ped_load(e));

    // full-scale single-sample train over a zero pedestal
    send(load_cmd(0, 0, 0));
    send(sample_cmd(0, 1023, 1'b0, 1'b1));
    // flat train: nothing beats zero, flag of first sample picks entry 64
    send(sample_cmd(0, 0, 1'b1, 1'b0));
    send(sample_cmd(0, 0, 1'b0, 1'b1));
    // tie: the earlier sample keeps the peak and its flag
    send(load_cmd(CHANNELS + 1, 0, 0));
    send(sample_cmd(1, 500, 1'b1, 1'b0));
    send(sample_cmd(1, 500, 1'b0, 1'b1));
    // missing channel mid-train is dropped and does not close the train
    send(sample_cmd(2, 300, 1'b0, 1'b0));
    send(sample_cmd(100, 1023, 1'b1, 1'b1));
    send(sample_cmd(2, 10, 1'b0, 1'b1));
    send(noise_cmd());
    // gate edge at 3.0 sigma: charge 48 stays out, 64 gets in
    send(load_cmd(3, 1600, 16));
    send(sample_cmd(3, 103, 1'b0, 1'b1));
    send(sample_cmd(3, 104, 1'b0, 1'b1));
    // top pedestal mean and sigma: charge always negative
    send(load_cmd(4, (1 << MEAN_W) - 1, (1 << SIGMA_W) - 1));
    send(sample_cmd(4, 1023, 1'b0, 1'b1));
    send(read_cmd(0));
    send(read_cmd(CHANNELS));
    send(read_cmd(CHANNELS + 1));
    send(read_cmd(2));
    send(read_cmd(3));
    send(read_cmd(4));

    // random phases over several sigma_cut settings, extremes included
    idling = 1'b1;
    random_phase(200);
    write_cut(0);
    random_phase(200);
    write_cut((1 << CUT_W) - 1);
    random_phase(200);
    write_cut($urandom_range(1, (1 << CUT_W) - 2));
    idling = 1'b0;
    random_phase(200);

    settle();
    $display("Run: %0d commands, %0d readbacks checked, %0d trains gated in, %0d gated out",
             sb.commands, sb.readbacks_checked, sb.accepted_trains, sb.gated_trains);
    $display("sigma_cut changed %0d times; flat, tied and out-of-range trains included",
             cut_writes);
    if (sb.errors == 0) begin
      $display("peak_charge_gate_accumulator_tb OK");
    end else begin
      $display("peak_charge_gate_accumulator_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/pcga_pkg.sv
rtl/core/pcga_ram.sv
rtl/core/pcga_peak.sv
rtl/core/pcga_gate.sv
rtl/core/pcga_div.sv
rtl/core/peak_charge_gate_accumulator.sv
tb/peak_charge_gate_accumulator_tb.sv
